// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the merger RTL.
// Each macro expects clk_i and rst_ni to be visible at the place of use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define KWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("merger assertion failed");

// Next-cycle implication.
`define KWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("merger assertion failed");

`endif

// ----- hdl/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwm_pkg
// Types and constants shared by the k-way record merger and its head cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int RUN_W    = 4;
  localparam int KEY_W    = 64;
  localparam int PAY_W    = 64;
  localparam int CNT_W    = 5;
  localparam int MAX_RUNS = 16;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 2;

  // Register map.
  localparam logic [APB_AW-1:0] ADDR_ACTIVE_RUNS = 2'd0;
  localparam logic [CNT_W-1:0]  ACTIVE_RUNS_RST  = 5'd16;

  // Broadcast write of one input transaction into the head cells.
  typedef struct packed {
    logic             en;
    logic [RUN_W-1:0] run;
    logic             run_end;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } wr_t;

  // Vacate the head of one run after it has been emitted.
  typedef struct packed {
    logic             en;
    logic [RUN_W-1:0] run;
  } clr_t;

  // Scan wave handed from cell to cell: the best head seen so far.
  typedef struct packed {
    logic             tok;
    logic             ok;
    logic             found;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [RUN_W-1:0] run;
  } scan_t;

endpackage

// ----- hdl/kway_record_merger.sv -----
// ----------------------------------------------------------------------------
// kway_record_merger
// Merges up to sixteen ascending runs of keyed records into one ascending
// stream. Each input transaction brings the next record of a run or marks the
// run as ended; a record leaves once every active run holds a head or has
// ended. The smallest key wins, ties going to the lower run, and out_run names
// the run to refill. The accepting edge writes the head; the scan wave then
// walks the row of head cells one cell per cycle, NR = min(NUM_RUNS, 16), and
// the control acts once the wave leaves the last cell. An item that releases
// nothing then frees the input by going back to idle. A released record
// moves the control to its emit state, from which it is loaded into the
// output register and offered; the next input can be accepted once that
// load is done. The load, and with it the next input, waits while the output
// register still holds a result the sink has not taken; otherwise the output
// register lets the next item be accepted while a result waits to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kway_record_merger #(
  parameter int NUM_RUNS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input records.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [63:0] key, [127:64] payload
  input  logic [127:0]               s_axis_tdata,
  // [3:0] run_index, [4] run_end
  input  logic [4:0]                 s_axis_tuser,
  // Merged records.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [63:0] out_key, [127:64] out_payload
  output logic [127:0]               m_axis_tdata,
  // [3:0] out_run
  output logic [3:0]                 m_axis_tuser,
  // Configuration.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kwm_pkg::APB_AW-1:0] paddr,
  input  logic [kwm_pkg::APB_DW-1:0] pwdata,
  output logic [kwm_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import kwm_pkg::*;

  localparam int NR = (NUM_RUNS < MAX_RUNS) ? NUM_RUNS : MAX_RUNS;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(NR);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] active_runs_q;
  logic [CNT_W-1:0] live;
  logic             start_q;
  logic             in_acc;
  logic             out_free;
  logic             load;
  logic             m_valid_q;
  logic [KEY_W-1:0] out_key_q;
  logic [PAY_W-1:0] out_pay_q;
  logic [RUN_W-1:0] out_run_q;
  wr_t              wr;
  clr_t             clr;
  scan_t            seed;
  scan_t            chain [NR];
  scan_t            last;
  logic [NR-1:0]    toks;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ACTIVE_RUNS) ?
                  {{(APB_DW-CNT_W){1'b0}}, active_runs_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_runs_q <= ACTIVE_RUNS_RST;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_ACTIVE_RUNS)) begin
      active_runs_q <= pwdata[CNT_W-1:0];
    end
  end

  // Zero counts as one run; anything above the row length is capped.
  always_comb begin
    if (active_runs_q == '0) begin
      live = CNT_W'(1);
    end else if (active_runs_q > CAP) begin
      live = CAP;
    end else begin
      live = active_runs_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign last          = chain[NR-1];
  assign load          = (state_q == ST_EMIT) && out_free;

  assign wr.en      = in_acc;
  assign wr.run     = s_axis_tuser[3:0];
  assign wr.run_end = s_axis_tuser[4];
  assign wr.key     = s_axis_tdata[63:0];
  assign wr.payload = s_axis_tdata[127:64];

  assign clr.en  = load;
  assign clr.run = last.run;

  always_comb begin
    seed       = '0;
    seed.tok   = start_q;
    seed.ok    = 1'b1;
  end

  for (genvar g = 0; g < NR; g++) begin : g_cell
    kwm_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .live_i (live),
      .wr_i   (wr),
      .clr_i  (clr),
      .scan_i ((g == 0) ? seed : chain[(g == 0) ? 0 : g-1]),
      .scan_o (chain[g])
    );
    assign toks[g] = chain[g].tok;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last.tok) begin
          state_d = (last.ok && last.found) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      start_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_acc;
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_key_q <= last.key;
      out_pay_q <= last.payload;
      out_run_q <= last.run;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_pay_q, out_key_q};
  assign m_axis_tuser  = out_run_q;

  `KWM_ASSERT_NEXT(a_start_scan, in_acc, start_q && (state_q == ST_SCAN))
  `KWM_ASSERT_NOW(a_one_wave, 1'b1, $onehot0({toks, start_q}))
  `KWM_ASSERT_NEXT(a_emit_after_win,
                   (state_q == ST_SCAN) && last.tok && last.ok && last.found,
                   state_q == ST_EMIT)
  `KWM_ASSERT_NOW(a_wave_only_in_scan, start_q || (toks != '0), state_q == ST_SCAN)

endmodule

// ----- hdl/kwm_cell.sv -----
// ----------------------------------------------------------------------------
// kwm_cell
// Holds the head record of one run and takes part in the scan wave: it
// compares its head against the best head handed in by its left neighbor and
// passes the winner on in the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kwm_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [kwm_pkg::CNT_W-1:0] live_i,
  input  kwm_pkg::wr_t              wr_i,
  input  kwm_pkg::clr_t             clr_i,
  input  kwm_pkg::scan_t            scan_i,
  output kwm_pkg::scan_t            scan_o
);
  import kwm_pkg::*;

  localparam logic [RUN_W-1:0] MY_RUN = RUN_W'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

  logic [KEY_W-1:0] key_q;
  logic [PAY_W-1:0] pay_q;
  logic             valid_q, valid_d;
  logic             exh_q, exh_d;
  logic             active;
  logic             hit;
  logic             take;
  scan_t            scan_q, scan_d;

  assign active = (MY_CNT < live_i);
  assign hit    = wr_i.en && (wr_i.run == MY_RUN) && active;

  always_comb begin
    valid_d = valid_q;
    exh_d   = exh_q;
    if (hit) begin
      if (wr_i.run_end) begin
        exh_d = 1'b1;
      end else if (!exh_q) begin
        valid_d = 1'b1;
      end
    end
    if (clr_i.en && (clr_i.run == MY_RUN)) begin
      valid_d = 1'b0;
    end
  end

  // Strict compare keeps the lower run on equal keys.
  assign take = active && valid_q && (!scan_i.found || (key_q < scan_i.key));

  always_comb begin
    scan_d     = scan_i;
    scan_d.ok  = scan_i.ok && (!active || valid_q || exh_q);
    if (take) begin
      scan_d.found   = 1'b1;
      scan_d.key     = key_q;
      scan_d.payload = pay_q;
      scan_d.run     = MY_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      exh_q   <= 1'b0;
      scan_q  <= '0;
    end else begin
      valid_q <= valid_d;
      exh_q   <= exh_d;
      if (scan_i.tok) begin
        scan_q <= scan_d;
      end else begin
        scan_q.tok <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit && !wr_i.run_end && !exh_q) begin
      key_q <= wr_i.key;
      pay_q <= wr_i.payload;
    end
  end

  assign scan_o = scan_q;

endmodule
